// ===== rtl/srec_pkg.sv =====
// Shared types, constants and the hex digit decoder for the S-record loader.
package srec_pkg;

   localparam int CHAR_W    = 8;
   localparam int ADDR_W    = 16;
   localparam int OFFSET_W  = 14;
   localparam int NIB_W     = 4;
   localparam int COUNT_W   = 8;
   localparam int POS_W     = 10;
   localparam int IDX_W     = POS_W - 1;
   localparam int DIFF_W    = ADDR_W + 2;

   localparam int WINDOW_SIZE = 16384;

   localparam logic [ADDR_W-1:0]  WINDOW_BASE_RESET = 16'h8000;
   localparam logic [POS_W-1:0]   POS_MAX           = {POS_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_OVERHEAD    = 8'd3;
   localparam logic [IDX_W-1:0]   DATA_START_PAIR   = 9'd4;

   localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_S     = 8'h53;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_SHIFT = 8'h20;
   localparam logic [NIB_W-1:0]  LETTER_ADJ = 4'd9;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [OFFSET_W-1:0] offset;
      logic [CHAR_W-1:0]   data_byte;
      logic                in_window;
   } srec_result_type;

   // Digit value; letters and junk wrap as (10 + c - 'A') mod 16.
   function automatic logic [NIB_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] u;
      u = c;
      if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         u = c - CASE_SHIFT;
      end
      if (u >= CHAR_ZERO && u <= CHAR_NINE) begin
         hex_value = NIB_W'(u - CHAR_ZERO);
      end else begin
         hex_value = u[NIB_W-1:0] + LETTER_ADJ;
      end
   endfunction

endpackage

// ===== rtl/srec_if.sv =====
// Valid/ready channel interfaces for characters in and results out.
interface srec_req_if import srec_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface srec_rsp_if import srec_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [OFFSET_W-1:0] offset;
   logic [CHAR_W-1:0]   data_byte;
   logic                in_window;
   modport source (output valid, output kind, output offset, output data_byte,
                   output in_window, input ready);
   modport sink   (input valid, input kind, input offset, input data_byte,
                   input in_window, output ready);
endinterface

// ===== rtl/srec_parser.sv =====
// Line parser: per-character state update and result formation.
module srec_parser import srec_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [CHAR_W-1:0]   char_in,
   input  logic [ADDR_W-1:0]   window_base,
   output logic                emit,
   output srec_result_type     result
);

   logic [POS_W-1:0]   pos_ff,      pos_in;
   logic               nine_ff,     nine_in;
   logic [COUNT_W-1:0] left_ff,     left_in;
   logic [ADDR_W-1:0]  addr_ff,     addr_in;
   logic [NIB_W-1:0]   hi_ff,       hi_in;
   logic               finished_ff, finished_in;

   logic [NIB_W-1:0]   nib;
   logic [COUNT_W-1:0] count;
   logic [IDX_W-1:0]   idx;
   logic [DIFF_W-1:0]  diff;
   logic               in_range;

   assign nib   = hex_value(char_in);
   assign count = {hi_ff, nib};
   assign idx   = pos_ff[POS_W-1:1] - DATA_START_PAIR;
   assign diff  = {2'b00, addr_ff} + {{(DIFF_W-IDX_W){1'b0}}, idx}
                  - {2'b00, window_base};
   // Negative differences set the top bit.
   assign in_range = !diff[DIFF_W-1] && (diff < DIFF_W'(WINDOW_SIZE));

   always_comb begin
      pos_in      = pos_ff;
      nine_in     = nine_ff;
      left_in     = left_ff;
      addr_in     = addr_ff;
      hi_in       = hi_ff;
      finished_in = finished_ff;
      emit        = 1'b0;
      result      = '0;
      if (accept && !finished_ff) begin
         if (char_in == CHAR_NL) begin
            if (nine_ff) begin
               emit        = 1'b1;
               result.kind = KIND_END;
               finished_in = 1'b1;
            end
            pos_in  = '0;
            nine_in = 1'b0;
            left_in = '0;
            addr_in = '0;
         end else begin
            if (pos_ff == POS_W'(0)) begin
               nine_in = (char_in == CHAR_S);
            end else if (pos_ff == POS_W'(1)) begin
               nine_in = nine_ff && (char_in == CHAR_NINE);
            end else if (pos_ff == POS_W'(2)) begin
               hi_in = nib;
            end else if (pos_ff == POS_W'(3)) begin
               left_in = (count >= COUNT_OVERHEAD) ? count - COUNT_OVERHEAD : '0;
            end else if (pos_ff <= POS_W'(7)) begin
               addr_in = {addr_ff[ADDR_W-NIB_W-1:0], nib};
            end else if (left_ff != '0) begin
               if (!pos_ff[0]) begin
                  hi_in = nib;
               end else begin
                  emit             = 1'b1;
                  result.kind      = KIND_DATA;
                  result.offset    = in_range ? diff[OFFSET_W-1:0] : '0;
                  result.data_byte = {hi_ff, nib};
                  result.in_window = in_range;
                  left_in          = left_ff - COUNT_W'(1);
               end
            end
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         nine_ff     <= 1'b0;
         left_ff     <= '0;
         addr_ff     <= '0;
         hi_ff       <= '0;
         finished_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         nine_ff     <= nine_in;
         left_ff     <= left_in;
         addr_ff     <= addr_in;
         hi_ff       <= hi_in;
         finished_ff <= finished_in;
      end
   end

endmodule

// ===== rtl/srec_out_reg.sv =====
// Result register driving the response channel.
module srec_out_reg import srec_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  srec_result_type result,
   output logic            can_take,
   srec_rsp_if.source      rsp
);

   logic            valid_ff, valid_in;
   srec_result_type data_ff,  data_in;

   // Free when empty or being drained this cycle.
   assign can_take = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (rsp.ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp.valid     = valid_ff;
   assign rsp.kind      = data_ff.kind;
   assign rsp.offset    = data_ff.offset;
   assign rsp.data_byte = data_ff.data_byte;
   assign rsp.in_window = data_ff.in_window;

endmodule

// ===== rtl/srecord_loader.sv =====
// Top level of the S-record loader: channels, window base register, parser, result register.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      char_in (8)
//   rsp_ch    out   valid / ready      kind, offset (14), data_byte (8), in_window
//   csr       in    csr_we             csr_wdata (16) -> window base
//
// One character per cycle while req_ch.ready is high: the parser state updates on
// the accepting edge and a result, if any, lands in the output register on that same edge.
// req_ch.ready is low only while the output register holds a result that is
// not being taken; stalls on rsp_ch hold the result and back-pressure input.
// Synchronous active-high reset clears the line state, the done flag and the
// output valid, and sets the window base to 0x8000. After an end record the
// block keeps taking characters and drops them until reset.
module srecord_loader import srec_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_wdata,
   srec_req_if.sink          req_ch,
   srec_rsp_if.source        rsp_ch
);

   logic [ADDR_W-1:0] base_ff, base_in;
   logic              accept;
   logic              emit;
   logic              can_take;
   srec_result_type   result;

   assign base_in = csr_we ? csr_wdata : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= WINDOW_BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   assign req_ch.ready = can_take;
   assign accept       = req_ch.valid && can_take;

   srec_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_in     (req_ch.char_in),
      .window_base (base_ff),
      .emit        (emit),
      .result      (result)
   );

   // emit is only raised for an accepted request, so the slot is free.
   srec_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (emit),
      .result   (result),
      .can_take (can_take),
      .rsp      (rsp_ch)
   );

endmodule

// ===== test/srecord_loader_tb.sv =====
// Self-checking testbench for the S-record loader: text stream in, memory writes out.
`timescale 1ns / 1ps

module srecord_loader_tb;
   import srec_pkg::*;

   // ------------------------------------------------------------------
   // Run sizing
   // ------------------------------------------------------------------
   localparam int CYCLE_LIMIT     = 400000;  // several times the slowest correct run
   localparam int CHARS_PER_PHASE = 160;     // four phases plus long line, ~1800 in all
   localparam int LONG_LINE_LEN   = 1040;    // runs the line position into saturation
   localparam int HOLD_CYCLES     = 300;     // long receiver hold-off in phase 0

   localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
   localparam string             HEX_DIGITS   = "0123456789ABCDEF";
   localparam string             RECORD_TYPES = "0123578";  // never type 9 mid-run

   // One row of the directed table: a character and, where it is obvious from
   // the record layout, the result it must produce.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              fixed;
      srec_result_type   res;
   } stim_row_type;

   localparam srec_result_type NO_RESULT = '0;
   localparam srec_result_type END_SEEN  = '{KIND_END, 14'd0, 8'h00, 1'b0};
   // base 0x8000, address 0x8000: first two bytes land at offsets 0 and 1
   localparam srec_result_type A_BYTE0   = '{KIND_DATA, 14'd0, 8'hFF, 1'b1};
   localparam srec_result_type A_BYTE1   = '{KIND_DATA, 14'd1, 8'h00, 1'b1};
   // address 0x7FFF sits one below the window; 'g','z' decode to 0 and 3
   localparam srec_result_type B_BYTE0   = '{KIND_DATA, 14'd0, 8'h03, 1'b0};

   // After reset (base 0x8000): an in-window record, then a record one byte
   // below the window with non-hex data characters and a trailing extra char.
   stim_row_type opening_rows [25] = '{
      '{"S", 1'b0, NO_RESULT}, '{"1", 1'b0, NO_RESULT},
      '{"0", 1'b0, NO_RESULT}, '{"5", 1'b0, NO_RESULT},
      '{"8", 1'b0, NO_RESULT}, '{"0", 1'b0, NO_RESULT},
      '{"0", 1'b0, NO_RESULT}, '{"0", 1'b0, NO_RESULT},
      '{"F", 1'b0, NO_RESULT}, '{"F", 1'b1, A_BYTE0},
      '{"0", 1'b0, NO_RESULT}, '{"0", 1'b1, A_BYTE1},
      '{CHAR_NL, 1'b0, NO_RESULT},
      '{"S", 1'b0, NO_RESULT}, '{"0", 1'b0, NO_RESULT},
      '{"0", 1'b0, NO_RESULT}, '{"4", 1'b0, NO_RESULT},
      '{"7", 1'b0, NO_RESULT}, '{"F", 1'b0, NO_RESULT},
      '{"F", 1'b0, NO_RESULT}, '{"F", 1'b0, NO_RESULT},
      '{"g", 1'b0, NO_RESULT}, '{"z", 1'b1, B_BYTE0},
      '{"5", 1'b0, NO_RESULT}, '{CHAR_NL, 1'b0, NO_RESULT}
   };

   // End record, then a full data record that must be swallowed.
   stim_row_type closing_rows [24] = '{
      '{"S", 1'b0, NO_RESULT}, '{"9", 1'b0, NO_RESULT},
      '{"0", 1'b0, NO_RESULT}, '{"3", 1'b0, NO_RESULT},
      '{"0", 1'b0, NO_RESULT}, '{"0", 1'b0, NO_RESULT},
      '{"0", 1'b0, NO_RESULT}, '{"0", 1'b0, NO_RESULT},
      '{"F", 1'b0, NO_RESULT}, '{"C", 1'b0, NO_RESULT},
      '{CHAR_NL, 1'b1, END_SEEN},
      '{"S", 1'b0, NO_RESULT}, '{"1", 1'b0, NO_RESULT},
      '{"0", 1'b0, NO_RESULT}, '{"5", 1'b0, NO_RESULT},
      '{"8", 1'b0, NO_RESULT}, '{"0", 1'b0, NO_RESULT},
      '{"0", 1'b0, NO_RESULT}, '{"0", 1'b0, NO_RESULT},
      '{"A", 1'b0, NO_RESULT}, '{"A", 1'b0, NO_RESULT},
      '{"0", 1'b0, NO_RESULT}, '{"0", 1'b0, NO_RESULT},
      '{CHAR_NL, 1'b0, NO_RESULT}
   };

   // ------------------------------------------------------------------
   // Clock, reset, DUT
   // ------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we;
   logic [ADDR_W-1:0] csr_wdata;

   srec_req_if req_ch ();
   srec_rsp_if rsp_ch ();

   always #5 clock = ~clock;

   srecord_loader u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // ------------------------------------------------------------------
   // Parser mirror: line state, window base and the results still owed
   // ------------------------------------------------------------------
   logic [POS_W-1:0]   pos_in_line;
   logic               s9_line;
   logic [COUNT_W-1:0] pairs_left;
   logic [ADDR_W-1:0]  line_addr;
   logic [NIB_W-1:0]   first_nib;
   logic               loader_done;
   logic [ADDR_W-1:0]  window_base_q;

   srec_result_type    pending_results [$];
   logic [CHAR_W-1:0]  line_chars [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_cycles   = 0;
   int error_count   = 0;
   int chars_sent    = 0;
   int lines_sent    = 0;
   int results_seen  = 0;
   int outside_seen  = 0;
   int base_writes   = 0;
   int cycle_count   = 0;

   // Uppercase first; digits by value, anything else wraps mod 16 from 'A' = 10.
   function automatic logic [NIB_W-1:0] nibble_of(input logic [CHAR_W-1:0] c);
      int u;
      u = c;
      if (u >= "a" && u <= "z") u = u - 32;
      if (u >= "0" && u <= "9") return NIB_W'(u - "0");
      return NIB_W'((10 + u - "A") & 15);
   endfunction

   // Advance the mirror by one accepted character; returns 1 when a result is due.
   function automatic bit decode_char(input logic [CHAR_W-1:0] c,
                                      output srec_result_type res);
      logic [NIB_W-1:0]   nib;
      logic [COUNT_W-1:0] cnt;
      int                 idx;
      int                 diff;
      bit                 in_range;
      bit                 got;
      got = 1'b0;
      res = NO_RESULT;
      if (loader_done) return 1'b0;

      if (c == CHAR_NL) begin
         if (s9_line) begin
            res         = END_SEEN;
            loader_done = 1'b1;
            got         = 1'b1;
         end
         pos_in_line = '0;
         s9_line     = 1'b0;
         pairs_left  = '0;
         line_addr   = '0;
         return got;
      end

      nib = nibble_of(c);
      if (pos_in_line == 0) begin
         s9_line = (c == CHAR_S);
      end else if (pos_in_line == 1) begin
         s9_line = s9_line && (c == CHAR_NINE);
      end else if (pos_in_line == 2) begin
         first_nib = nib;
      end else if (pos_in_line == 3) begin
         cnt        = {first_nib, nib};
         pairs_left = (cnt >= 8'd3) ? cnt - 8'd3 : 8'd0;
      end else if (pos_in_line <= 7) begin
         line_addr = {line_addr[ADDR_W-NIB_W-1:0], nib};
      end else if (pairs_left != 0) begin
         if (!pos_in_line[0]) begin
            first_nib = nib;
         end else begin
            idx            = (int'(pos_in_line) - 8) >> 1;
            diff           = int'(line_addr) + idx - int'(window_base_q);
            in_range       = (diff >= 0) && (diff < WINDOW_SIZE);
            res.kind       = KIND_DATA;
            res.offset     = in_range ? OFFSET_W'(diff) : '0;
            res.data_byte  = {first_nib, nib};
            res.in_window  = in_range;
            pairs_left     = pairs_left - 8'd1;
            got            = 1'b1;
         end
      end
      if (pos_in_line != POS_MAX) pos_in_line = pos_in_line + 1'b1;
      return got;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Offer one character, wait for the handshake, then book what it owes.
   // Returns at the accepting edge with valid still high, so the next call
   // either keeps it high or drops it for a gap - one assignment per edge.
   task automatic send_char(input logic [CHAR_W-1:0] ch, input bit use_fixed,
                            input srec_result_type fixed_res);
      srec_result_type predicted;
      bit              got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.char_in <= ch;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      got = decode_char(ch, predicted);
      // typed rows override the mirror; the mirror still tracks line state
      if (use_fixed) pending_results.push_back(fixed_res);
      else if (got) pending_results.push_back(predicted);
      chars_sent++;
   endtask

   function automatic logic [CHAR_W-1:0] random_text_char();
      logic [CHAR_W-1:0] c;
      c = CHAR_W'($urandom_range(255));
      if (c == CHAR_NL) c = 8'h8A;  // newlines are placed on purpose only
      return c;
   endfunction

   // Hex digit in random case; now and then a junk character in its place.
   function automatic void push_digit(input logic [NIB_W-1:0] nib);
      logic [CHAR_W-1:0] c;
      c = HEX_DIGITS[nib];
      if ($urandom_range(99) < 4) c = random_text_char();
      else if (nib > 9 && $urandom_range(99) < 30) c = c + 8'h20;
      line_chars.push_back(c);
   endfunction

   // Send the built line plus newline. A line that opens "S9" (or is a lone
   // 'S') would end the stream early, so its lead is lowered to 's'.
   task automatic send_line();
      if (line_chars.size() > 0 && line_chars[0] == CHAR_S &&
          (line_chars.size() == 1 || line_chars[1] == CHAR_NINE)) begin
         line_chars[0] = "s";
      end
      foreach (line_chars[i]) send_char(line_chars[i], 1'b0, NO_RESULT);
      send_char(CHAR_NL, 1'b0, NO_RESULT);
      lines_sent++;
   endtask

   // Mostly well-formed records with random content aimed around the window
   // edges; some cut short anywhere, some pure noise.
   task automatic send_record();
      int                 sel;
      int                 pick;
      int                 nbytes;
      int                 cut;
      logic [COUNT_W-1:0] cnt;
      logic [ADDR_W-1:0]  addr;
      line_chars.delete();
      sel = $urandom_range(99);
      if (sel < 92) begin
         line_chars.push_back(CHAR_S);
         line_chars.push_back(RECORD_TYPES[$urandom_range(6)]);
         pick = $urandom_range(99);
         if (pick < 8) begin
            cnt    = COUNT_W'($urandom_range(2));  // count below overhead
            nbytes = $urandom_range(3);
         end else if (pick == 99) begin
            cnt    = 8'hFF;
            nbytes = 252;
         end else begin
            nbytes = $urandom_range(1, 12);
            cnt    = COUNT_W'(nbytes + 3);
         end
         case ($urandom_range(3))
            0: addr = window_base_q - ADDR_W'($urandom_range(1, 16));
            1: addr = window_base_q + ADDR_W'($urandom_range(16383));
            2: addr = window_base_q + ADDR_W'(WINDOW_SIZE - $urandom_range(16));
            default: addr = ADDR_W'($urandom_range(65535));
         endcase
         push_digit(cnt[7:4]);
         push_digit(cnt[3:0]);
         for (int i = 3; i >= 0; i--) push_digit(addr[i*4 +: 4]);
         for (int i = 0; i < nbytes; i++) begin
            push_digit(NIB_W'($urandom_range(15)));
            push_digit(NIB_W'($urandom_range(15)));
         end
         push_digit(NIB_W'($urandom_range(15)));  // checksum, never checked
         push_digit(NIB_W'($urandom_range(15)));
         if ($urandom_range(1)) line_chars.push_back(CHAR_CR);
         if (sel >= 80) begin
            cut = $urandom_range(line_chars.size() - 1);
            while (line_chars.size() > cut) void'(line_chars.pop_back());
         end
      end else begin
         repeat ($urandom_range(12)) line_chars.push_back(random_text_char());
      end
      send_line();
   endtask

   // Drop valid, let every owed result drain, then idle for a margin.
   task automatic pause_for_drain();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_window_base(input logic [ADDR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we        <= 1'b0;
      window_base_q  = value;
      base_writes++;
   endtask

   // ------------------------------------------------------------------
   // Result side: random stalls plus a counted hold-off on request
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles   = hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      srec_result_type got_res;
      srec_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_res = '{rsp_ch.kind, rsp_ch.offset, rsp_ch.data_byte, rsp_ch.in_window};
         results_seen++;
         if (got_res.kind == KIND_DATA && !got_res.in_window) outside_seen++;
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t ERROR: unexpected result kind=%0d offset=%h byte=%h win=%0d",
                     $time, got_res.kind, got_res.offset, got_res.data_byte,
                     got_res.in_window);
         end else begin
            want = pending_results.pop_front();
            if (got_res.kind !== want.kind || got_res.offset !== want.offset ||
                got_res.data_byte !== want.data_byte ||
                got_res.in_window !== want.in_window) begin
               error_count++;
               $display("%0t ERROR: expected kind=%0d offset=%h byte=%h win=%0d, %s",
                        $time, want.kind, want.offset, want.data_byte, want.in_window,
                        $sformatf("got kind=%0d offset=%h byte=%h win=%0d",
                                  got_res.kind, got_res.offset, got_res.data_byte,
                                  got_res.in_window));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ERROR: timeout, %0d results still owed", $time,
                  pending_results.size());
         $display("** srecord_loader: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int          phase_start;
      bit          held;
      bit          paused;
      logic [15:0] base_plan [4];
      req_ch.valid   = 1'b0;
      req_ch.char_in = '0;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;

      // mirror of the reset state
      pos_in_line   = '0;
      s9_line       = 1'b0;
      pairs_left    = '0;
      line_addr     = '0;
      first_nib     = '0;
      loader_done   = 1'b0;
      window_base_q = WINDOW_BASE_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset base, in-window bytes, below-window byte, junk digits
      foreach (opening_rows[i]) begin
         send_char(opening_rows[i].ch, opening_rows[i].fixed, opening_rows[i].res);
      end

      // Random phases: base at both extremes, a random one, then reset value.
      // Idling: none / sender 64% / receiver 64% / both 23%.
      base_plan[0] = 16'h0000;
      base_plan[1] = 16'hFFFF;
      base_plan[2] = 16'($urandom_range(65535));
      base_plan[3] = 16'h8000;
      for (int ph = 0; ph < 4; ph++) begin
         pause_for_drain();
         write_window_base(base_plan[ph]);
         send_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 23 : 0;
         stall_pct     = (ph == 2) ? 64 : (ph == 3) ? 23 : 0;
         phase_start   = chars_sent;
         held          = 1'b0;
         paused        = 1'b0;
         while (chars_sent - phase_start < CHARS_PER_PHASE) begin
            // receiver goes quiet while characters keep coming: input backs up
            if (ph == 0 && !held && chars_sent - phase_start > 100) begin
               hold_cycles = HOLD_CYCLES;
               held        = 1'b1;
            end
            // sender stops until nothing is owed, then resumes mid-phase
            if (ph == 2 && !paused && chars_sent - phase_start > 80) begin
               pause_for_drain();
               paused = 1'b1;
            end
            send_record();
         end
         // one oversized noise line: line position pins at its maximum
         if (ph == 1) begin
            line_chars.delete();
            repeat (LONG_LINE_LEN) line_chars.push_back(random_text_char());
            send_line();
         end
      end

      // End record, then input that must be ignored; the register stays writable
      pause_for_drain();
      send_idle_pct = 0;
      stall_pct     = 0;
      foreach (closing_rows[i]) begin
         send_char(closing_rows[i].ch, closing_rows[i].fixed, closing_rows[i].res);
      end
      pause_for_drain();
      write_window_base(16'h1234);
      send_record();
      pause_for_drain();
      repeat (8) @(posedge clock);

      $display("Covered %0d characters in %0d lines, %0d results (%0d outside window).",
               chars_sent, lines_sent, results_seen, outside_seen);
      $display("Window base written %0d times; four idling mixes, hold-off, end record.",
               base_writes);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("** srecord_loader: PASSED **");
      end else begin
         $display("** srecord_loader: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/srec_pkg.sv
rtl/srec_if.sv
rtl/srec_parser.sv
rtl/srec_out_reg.sv
rtl/srecord_loader.sv
test/srecord_loader_tb.sv
